>>> rtl/core/bpa_pkg.sv
// Shared types and constants for the binary patch applier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // Longest length field whose bytes are still folded into the run length
  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LEN_KEEP = (MAX_LENGTH_BYTES < 4) ? MAX_LENGTH_BYTES : 4;

  localparam logic [3:0] ACT_SIZE = 4'h1;
  localparam logic [3:0] ACT_ADD  = 4'h2;
  localparam logic [3:0] ACT_DEL  = 4'h3;
  localparam logic [3:0] ACT_COPY = 4'h4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_SIZE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LENGTH = 5'b00010,
    PH_ADD    = 5'b00100,
    PH_COPY   = 5'b01000,
    PH_DEL    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       from_old;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  obyte;
    logic [31:0] size;
    logic        need_old;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bpa_in_stage.sv
// Input register of the patch applier: holds one accepted item for the core.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_in_stage
  import bpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       held_valid,
  output item_t      held_item,
  input  wire logic  held_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_ready  = !valid_r || held_take;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept ? 1'b1 : (held_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

`default_nettype wire

>>> rtl/core/bpa_core.sv
// Record parser state, per-item step logic and the result register.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_core
  import bpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_take,
  output logic       res_valid,
  output result_t    res,
  input  wire logic  res_ready
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  action_r, action_nxt;
  logic [3:0]  len_total_r, len_total_nxt;
  logic [3:0]  len_idx_r, len_idx_nxt;
  logic [31:0] run_r, run_nxt;
  logic        out_valid_r;
  result_t     out_r, step_res;

  logic        wants_old;
  logic [3:0]  idx_inc;
  logic [31:0] run_or;
  logic [31:0] run_dec;
  logic [3:0]  hdr_act;
  logic [3:0]  fin_act;
  logic [31:0] fin_run;

  assign item_take = item_valid && (!out_valid_r || res_ready);
  assign wants_old = (phase_r == PH_COPY) || (phase_r == PH_DEL);
  assign idx_inc   = len_idx_r + 4'd1;
  assign run_dec   = run_r - 32'd1;
  assign hdr_act   = item.value[3:0];

  always_comb begin
    run_or = run_r;
    if (len_idx_r < 4'(LEN_KEEP)) begin
      run_or = run_r | ({24'd0, item.value} << {len_idx_r[1:0], 3'b000});
    end
  end

  // Action and run length of a record whose header is complete this item
  assign fin_act = (phase_r == PH_LENGTH) ? action_r : hdr_act;
  assign fin_run = (phase_r == PH_LENGTH) ? run_or : 32'd0;

  always_comb begin
    phase_nxt     = phase_r;
    action_nxt    = action_r;
    len_total_nxt = len_total_r;
    len_idx_nxt   = len_idx_r;
    run_nxt       = run_r;
    step_res      = '0;
    if (item.from_old != wants_old) begin
      step_res.kind = KIND_ERR;
    end else begin
      case (phase_r)
        PH_LENGTH: begin
          run_nxt     = run_or;
          len_idx_nxt = idx_inc;
          if (idx_inc >= len_total_r) begin
            phase_nxt = PH_HEADER;
            if (fin_act == ACT_SIZE) begin
              step_res.kind = KIND_SIZE;
              step_res.size = fin_run;
            end else if (fin_run != 32'd0) begin
              case (fin_act)
                ACT_ADD:  phase_nxt = PH_ADD;
                ACT_COPY: phase_nxt = PH_COPY;
                ACT_DEL:  phase_nxt = PH_DEL;
                default:  phase_nxt = PH_HEADER;
              endcase
            end
          end
        end
        PH_ADD, PH_COPY: begin
          step_res.kind  = KIND_BYTE;
          step_res.obyte = item.value;
          run_nxt        = run_dec;
          if (run_dec == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_DEL: begin
          run_nxt = run_dec;
          if (run_dec == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          // Header byte; an empty length field closes the record at once
          action_nxt    = hdr_act;
          len_total_nxt = item.value[7:4];
          len_idx_nxt   = 4'd0;
          run_nxt       = 32'd0;
          if (item.value[7:4] == 4'd0) begin
            phase_nxt = PH_HEADER;
            if (hdr_act == ACT_SIZE) begin
              step_res.kind = KIND_SIZE;
            end
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
      endcase
    end
    step_res.need_old = (phase_nxt == PH_COPY) || (phase_nxt == PH_DEL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      action_r    <= 4'd0;
      len_total_r <= 4'd0;
      len_idx_r   <= 4'd0;
      run_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r     <= phase_nxt;
        action_r    <= action_nxt;
        len_total_r <= len_total_nxt;
        len_idx_r   <= len_idx_nxt;
        run_r       <= run_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_r <= step_res;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

>>> rtl/core/binary_patch_applier.sv
// Binary patch applier: rebuilds a new file from patch and old-file bytes.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while out_tready is high, one result per item.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the expect-header phase with cleared record state.
// Depends on bpa_pkg, bpa_in_stage and bpa_core.
`timescale 1ns / 1ps
`default_nettype none

module binary_patch_applier
  import bpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic [0:0]  in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] out_byte, [39:8] announced_size,
                                       // [40] need_old, [47:41] zero
  output logic [1:0]       out_tuser   // [1:0] result_kind
);

  item_t   in_item, held_item;
  logic    held_valid, held_take;
  result_t res;

  assign in_item.from_old = in_tuser[0];
  assign in_item.value    = in_tdata;

  bpa_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .held_take  (held_take)
  );

  bpa_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (held_valid),
    .item       (held_item),
    .item_take  (held_take),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = {7'd0, res.need_old, res.size, res.obyte};
  assign out_tuser = res.kind;

  // Input side stalls only behind a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

  a_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_BYTE |-> out_tdata[7:0] == 8'd0)
    else $error("out_byte set on a non-byte result");

  a_size_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_SIZE |-> out_tdata[39:8] == 32'd0)
    else $error("announced_size set on a non-size result");

endmodule

`default_nettype wire

>>> tb/binary_patch_applier_test.sv
// Self-checking testbench for binary_patch_applier: drives patch and old-file
// bytes as stream items and checks every result against a built-in predictor.
// Depends on bpa_pkg and the binary_patch_applier RTL.
`timescale 1ns / 1ps

module binary_patch_applier_test;
  import bpa_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;

  // Predicts the rebuilt-file results and holds the ones still due
  class patch_scoreboard;
    phase_t      phase = PH_HEADER;
    logic [3:0]  action = '0;
    logic [3:0]  len_total = '0;
    logic [3:0]  len_idx = '0;
    logic [31:0] run_left = '0;
    result_t     due_results[$];
    int          mismatches = 0;

    function bit needs_old();
      return (phase == PH_COPY) || (phase == PH_DEL);
    endfunction

    // Header and length are done: pick the data phase, flag a size report
    function bit close_header();
      phase = PH_HEADER;
      if (action == ACT_SIZE) return 1'b1;
      if (run_left != 0) begin
        if (action == ACT_ADD) phase = PH_ADD;
        else if (action == ACT_COPY) phase = PH_COPY;
        else if (action == ACT_DEL) phase = PH_DEL;
      end
      return 1'b0;
    endfunction

    function result_t rebuild_step(bit from_old, logic [7:0] b);
      result_t r;
      r = '0;
      if (from_old != needs_old()) begin
        r.kind = KIND_ERR;
      end else begin
        case (phase)
          PH_LENGTH: begin
            if (len_idx < LEN_KEEP) run_left |= 32'(b) << (8 * len_idx);
            len_idx = len_idx + 4'd1;
            if (len_idx >= len_total && close_header()) begin
              r.kind = KIND_SIZE;
              r.size = run_left;
            end
          end
          PH_ADD, PH_COPY: begin
            r.kind = KIND_BYTE;
            r.obyte = b;
            run_left = run_left - 1;
            if (run_left == 0) phase = PH_HEADER;
          end
          PH_DEL: begin
            run_left = run_left - 1;
            if (run_left == 0) phase = PH_HEADER;
          end
          default: begin
            action = b[3:0];
            len_total = b[7:4];
            len_idx = '0;
            run_left = '0;
            if (len_total == 0) begin
              if (close_header()) r.kind = KIND_SIZE;
            end else begin
              phase = PH_LENGTH;
            end
          end
        endcase
      end
      r.need_old = needs_old();
      return r;
    endfunction

    function void note_item(bit from_old, logic [7:0] b);
      result_t step_r;
      step_r = rebuild_step(from_old, b);
      due_results = {due_results, step_r};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: kind %0d byte %h size %h need_old %0d",
                   got.kind, got.obyte, got.size, got.need_old);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.obyte !== want.obyte ||
          got.size !== want.size || got.need_old !== want.need_old) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display({"mismatch: expected kind %0d byte %h size %h need_old %0d,",
                    " got kind %0d byte %h size %h need_old %0d"},
                   want.kind, want.obyte, want.size, want.need_old,
                   got.kind, got.obyte, got.size, got.need_old);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_value
  logic [0:0]  in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] out_byte, [39:8] announced_size, [40] need_old
  logic [1:0]  out_tuser;  // [1:0] result_kind

  patch_scoreboard sb = new;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  send_gaps_on = 1'b1;
  bit  recv_stalls_on = 1'b1;

  binary_patch_applier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one item after a random gap and hand it to the scoreboard on acceptance
  task automatic send_item(bit from_old, logic [7:0] b);
    int gap;
    if (items_sent % 64 == 0) send_gaps_on = ($urandom_range(0, 2) != 0);
    gap = send_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= from_old;
    do @(posedge clk); while (!in_tready);
    sb.note_item(from_old, b);
    items_sent++;
  endtask

  // Occasionally slip in a byte from the stream the block does not want
  task automatic send_noisy(bit from_old, logic [7:0] b);
    if ($urandom_range(0, 99) < 6) send_item(!sb.needs_old(), 8'($urandom));
    send_item(from_old, b);
  endtask

  // Hold the input until every due result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_record();
    logic [3:0]  act;
    logic [3:0]  nlen;
    logic [31:0] run_len;
    bit          data_rec;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) act = ACT_ADD;
    else if (pick < 45) act = ACT_COPY;
    else if (pick < 60) act = ACT_DEL;
    else if (pick < 75) act = ACT_SIZE;
    else begin
      // unknown action: anything outside the four defined codes
      do act = 4'($urandom); while (act >= ACT_SIZE && act <= ACT_COPY);
    end
    data_rec = (act == ACT_ADD) || (act == ACT_COPY) || (act == ACT_DEL);
    nlen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(3, 15)) : 4'($urandom_range(0, 2));
    run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    if (nlen == 0) run_len = 0;
    send_noisy(1'b0, {nlen, act});
    for (int i = 0; i < nlen; i++) begin
      if (data_rec && i < 4) send_noisy(1'b0, 8'(run_len >> (8 * i)));
      else send_noisy(1'b0, 8'($urandom));
    end
    if (data_rec)
      for (int i = 0; i < run_len; i++) send_noisy(act != ACT_ADD, 8'($urandom));
  endtask

  // Result side: random stalls, then take and check one item
  initial begin
    int stall;
    result_t got;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_seen % 64 == 0) recv_stalls_on = ($urandom_range(0, 2) != 0);
      stall = recv_stalls_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      got.kind     = out_tuser;
      got.obyte    = out_tdata[7:0];
      got.size     = out_tdata[39:8];
      got.need_old = out_tdata[40];
      sb.check_result(got);
      results_seen++;
    end
  end

  initial begin
    bit drained_once;
    drained_once = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size record without length bytes
    send_item(1'b0, {4'd0, ACT_SIZE});
    // old byte while a header is expected
    send_item(1'b1, 8'h3c);
    // largest announced size
    send_item(1'b0, {4'd4, ACT_SIZE});
    repeat (4) send_item(1'b0, 8'hff);
    // add three bytes, with a wrong-stream byte inside the run
    send_item(1'b0, {4'd1, ACT_ADD});
    send_item(1'b0, 8'h03);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'hff);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h5a);
    // copy two old bytes, with a patch byte inside the run
    send_item(1'b0, {4'd1, ACT_COPY});
    send_item(1'b0, 8'h02);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h77);
    send_item(1'b1, 8'hff);
    // delete one old byte
    send_item(1'b0, {4'd1, ACT_DEL});
    send_item(1'b0, 8'h01);
    send_item(1'b1, 8'ha5);
    // zero-length add, zero-length copy through its length byte
    send_item(1'b0, {4'd0, ACT_ADD});
    send_item(1'b0, {4'd1, ACT_COPY});
    send_item(1'b0, 8'h00);
    // unknown action with a length byte
    send_item(1'b0, 8'h1f);
    send_item(1'b0, 8'h12);
    // fifth length byte is dropped: run of one byte
    send_item(1'b0, {4'd5, ACT_ADD});
    send_item(1'b0, 8'h01);
    repeat (3) send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h7e);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      send_record();
      if (!drained_once && items_sent > ITEM_TARGET / 2) begin
        drained_once = 1'b1;
        drain_results();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_in_stage.sv
rtl/core/bpa_core.sv
rtl/core/binary_patch_applier.sv
tb/binary_patch_applier_test.sv
